// File: sv/abdf_pkg.sv
// ============================================================================
// abdf_pkg - shared types and constants for the anchor box decode filter
// Stage map, register indexes and reset values, exp2 fraction table.
// ============================================================================
`default_nettype none

package abdf_pkg;

  // Pipeline stage map (index of the register bank loaded at each stage)
  localparam int NUM_STAGES = 21;
  localparam int ST_IN      = 0;   // variance products
  localparam int ST_PROD    = 1;   // log2e product, centre sum
  localparam int ST_EXP     = 2;   // integer/fraction split of the exponent
  localparam int ST_MANT0   = 3;   // first of the fraction steps
  localparam int MANT_STEPS = 12;
  localparam int ST_HMUL    = 15;  // size times mantissa
  localparam int ST_SHIFT   = 16;  // scale by power of two
  localparam int ST_CORNER  = 17;  // corners, unit clamp
  localparam int ST_SCALE   = 18;  // times image size
  localparam int ST_CLAMP   = 19;  // pixel clamp
  localparam int ST_OUT     = 20;  // position and length

  // Bounds on class and prior index
  localparam int MAX_PRIORS  = 32768;
  localparam int MAX_CLASSES = 128;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VAR_CX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_CY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H     = 3'd6;

  localparam logic [15:0] RST_VAR_C     = 16'd6554;
  localparam logic [15:0] RST_VAR_S     = 16'd13107;
  localparam logic [15:0] RST_SCORE_THR = 16'd3277;
  localparam logic [12:0] RST_IMG_W     = 13'd640;
  localparam logic [12:0] RST_IMG_H     = 13'd480;

  // log2(e) in Q2.30
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

  // 1.0 in Q1.30 and the rounding constant for a Q1.30 product
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [61:0] ROUND_Q30 = 62'h2000_0000;

  // 2^(2^-k) in Q1.30, k = 1 .. 12
  localparam logic [30:0] POW2_FRAC [MANT_STEPS] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196444, 31'd1074468888, 31'd1074105294, 31'd1073923544
  };

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] var_cx;
    logic [15:0] var_cy;
    logic [15:0] var_w;
    logic [15:0] var_h;
    logic [15:0] score_thr;
    logic [12:0] img_w;
    logic [12:0] img_h;
  } cfg_t;

  // Fields that ride along the pipeline untouched
  typedef struct packed {
    logic [6:0]  class_id;
    logic [15:0] score;
    logic [14:0] prior_ref;
  } side_t;

endpackage

`default_nettype wire

// File: sv/abdf_cfg.sv
// ============================================================================
// abdf_cfg - configuration register file
// Seven write-only registers loaded from the plain write port.
// ============================================================================
`default_nettype none

module abdf_cfg
  import abdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; indexes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_VAR_CX:    cfg_nxt.var_cx    = cfg_wdata;
        CFG_VAR_CY:    cfg_nxt.var_cy    = cfg_wdata;
        CFG_VAR_W:     cfg_nxt.var_w     = cfg_wdata;
        CFG_VAR_H:     cfg_nxt.var_h     = cfg_wdata;
        CFG_SCORE_THR: cfg_nxt.score_thr = cfg_wdata;
        CFG_IMG_W:     cfg_nxt.img_w     = cfg_wdata[12:0];
        CFG_IMG_H:     cfg_nxt.img_h     = cfg_wdata[12:0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.var_cx    <= RST_VAR_C;
      cfg_r.var_cy    <= RST_VAR_C;
      cfg_r.var_w     <= RST_VAR_S;
      cfg_r.var_h     <= RST_VAR_S;
      cfg_r.score_thr <= RST_SCORE_THR;
      cfg_r.img_w     <= RST_IMG_W;
      cfg_r.img_h     <= RST_IMG_H;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: sv/abdf_ctrl.sv
// ============================================================================
// abdf_ctrl - pipeline control and side-band carry
// Filters items on class and score, moves valid bits and pass-through
// fields down the stages and derives the per-stage load enables.
// ============================================================================
`default_nettype none

module abdf_ctrl
  import abdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  side_t                      in_side,
  input  wire logic [15:0]           score_thr,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output side_t                      out_side,
  output logic [NUM_STAGES-1:0]      en
);

  logic [NUM_STAGES-1:0] v_r;
  side_t                 side_r [NUM_STAGES];
  logic                  keep;

  // Keep only foreground classes whose score beats the threshold
  assign keep = (in_side.class_id != 7'd0) && (in_side.score > score_thr) &&
                (int'(in_side.class_id) < MAX_CLASSES) &&
                (int'(in_side.prior_ref) < MAX_PRIORS);

  // A stage may load when some stage at or after it is empty or the output drains
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = out_ready || !(&v_r[NUM_STAGES-1:k]);
  end

  assign in_ready = en[ST_IN];

  // First stage: dropped items are accepted and leave a bubble
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[ST_IN] <= 1'b0;
    end else if (en[ST_IN]) begin
      v_r[ST_IN] <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      side_r[ST_IN] <= in_side;
    end
  end

  // Advance valid bits and side-band down the pipe
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[ST_OUT];
  assign out_side  = side_r[ST_OUT];

  // Filter decision reaches the first stage
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !keep |=> !v_r[ST_IN])
    else $error("dropped item entered the pipeline");

  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && keep |=> v_r[ST_IN])
    else $error("kept item lost at pipeline entry");

  // Input back-pressure only with a full pipe and a stalled output
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("input stalled while the pipeline has room");

  // A bubble behind a taken result reaches the output
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !v_r[ST_OUT-1] |=> !out_valid)
    else $error("result repeated after hand-over");

endmodule

`default_nettype wire

// File: sv/abdf_axis.sv
// ============================================================================
// abdf_axis - one axis of the box decode datapath
// Centre shift, exp2 of the scaled log delta by a twelve-step fraction
// chain, corner scaling and clamping to the image, pixel position/length.
// ============================================================================
`default_nettype none

module abdf_axis
  import abdf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [NUM_STAGES-1:0]  en,
  input  wire logic [15:0]            var_c,
  input  wire logic [15:0]            var_s,
  input  wire logic [12:0]            dim,
  input  wire logic signed [15:0]     delta_c,
  input  wire logic signed [15:0]     delta_s,
  input  wire logic [15:0]            prior_c,
  input  wire logic [15:0]            prior_size,
  output logic [11:0]                 pos,
  output logic [12:0]                 len
);

  localparam logic signed [17:0] U_MIN  = -18'sd49152;
  localparam logic signed [17:0] U_MAX  = 18'sd49151;
  localparam logic signed [56:0] ONE_Q44 = 57'sd17592186044416;

  // Clamp a Q.44 corner to [0, 1.0]
  function automatic logic [44:0] clamp_unit(input logic signed [56:0] x);
    logic [44:0] r;
    if (x < 57'sd0) begin
      r = 45'd0;
    end else if (x > ONE_Q44) begin
      r = ONE_Q44[44:0];
    end else begin
      r = x[44:0];
    end
    return r;
  endfunction

  // ---- stage 0: variance products ----
  logic signed [32:0] e_nxt, cm_nxt;
  logic signed [32:0] e_s0_r, cm_s0_r;
  logic [15:0]        pc_s0_r, size_s0_r;

  assign e_nxt  = $signed({1'b0, var_s}) * delta_s;
  assign cm_nxt = $signed({1'b0, var_c}) * delta_c;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      e_s0_r    <= e_nxt;
      cm_s0_r   <= cm_nxt;
      pc_s0_r   <= prior_c;
      size_s0_r <= prior_size;
    end
  end

  // ---- stage 1: exponent times log2(e), centre in Q.44 ----
  logic signed [63:0] prod_nxt;
  logic signed [49:0] c_nxt;
  logic signed [63:0] prod_s1_r;
  logic signed [49:0] c_s1_r;
  logic [15:0]        size_s1_r;

  assign prod_nxt = e_s0_r * $signed(LOG2E_Q30);
  assign c_nxt    = cm_s0_r * $signed({1'b0, size_s0_r}) +
                    $signed({1'b0, pc_s0_r, 28'd0});

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      prod_s1_r <= prod_nxt;
      c_s1_r    <= c_nxt;
      size_s1_r <= size_s0_r;
    end
  end

  // ---- stage 2: floor to Q.12, saturate, split integer and fraction ----
  logic signed [17:0] u_raw;
  logic signed [16:0] u_sat;

  assign u_raw = prod_s1_r[63:46];

  always_comb begin
    if (u_raw < U_MIN) begin
      u_sat = U_MIN[16:0];
    end else if (u_raw > U_MAX) begin
      u_sat = U_MAX[16:0];
    end else begin
      u_sat = u_raw[16:0];
    end
  end

  logic [30:0]        mant_r [MANT_STEPS+1];
  logic [11:0]        f_r    [MANT_STEPS+1];
  logic signed [4:0]  n_r    [MANT_STEPS+1];
  logic signed [49:0] c_r    [MANT_STEPS+1];
  logic [15:0]        size_r [MANT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en[ST_EXP]) begin
      mant_r[0] <= ONE_Q30;
      f_r[0]    <= u_sat[11:0];
      n_r[0]    <= u_sat[16:12];
      c_r[0]    <= c_s1_r;
      size_r[0] <= size_s1_r;
    end
  end

  // ---- stages 3..14: one fraction bit per stage, highest weight first ----
  for (genvar i = 0; i < MANT_STEPS; i++) begin : g_mant
    logic [61:0] mprod;
    logic [61:0] mrnd;

    assign mprod = 62'(mant_r[i]) * 62'(POW2_FRAC[i]);
    assign mrnd  = mprod + ROUND_Q30;

    always_ff @(posedge clk) begin
      if (en[ST_MANT0+i]) begin
        mant_r[i+1] <= f_r[i][MANT_STEPS-1-i] ? mrnd[60:30] : mant_r[i];
        f_r[i+1]    <= f_r[i];
        n_r[i+1]    <= n_r[i];
        c_r[i+1]    <= c_r[i];
        size_r[i+1] <= size_r[i];
      end
    end
  end

  // ---- stage 15: size times mantissa ----
  logic [46:0]        h_s15_r;
  logic signed [4:0]  n_s15_r;
  logic signed [49:0] c_s15_r;

  always_ff @(posedge clk) begin
    if (en[ST_HMUL]) begin
      h_s15_r <= 47'(size_r[MANT_STEPS]) * 47'(mant_r[MANT_STEPS]);
      n_s15_r <= n_r[MANT_STEPS];
      c_s15_r <= c_r[MANT_STEPS];
    end
  end

  // ---- stage 16: shift by n-3 (left up to 8, right up to 15) ----
  logic signed [5:0] sh;
  logic [5:0]        sh_neg;
  logic [54:0]       hs_nxt;
  logic [54:0]       hs_s16_r;
  logic signed [49:0] c_s16_r;

  assign sh     = {n_s15_r[4], n_s15_r} - 6'sd3;
  assign sh_neg = 6'(-sh);

  always_comb begin
    if (!sh[5]) begin
      hs_nxt = {8'd0, h_s15_r} << sh[3:0];
    end else begin
      hs_nxt = {8'd0, h_s15_r} >> sh_neg[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SHIFT]) begin
      hs_s16_r <= hs_nxt;
      c_s16_r  <= c_s15_r;
    end
  end

  // ---- stage 17: corners, clamp to the unit range ----
  logic signed [56:0] x1, x2;
  logic [44:0]        x1_s17_r, x2_s17_r;

  assign x1 = c_s16_r - $signed({1'b0, hs_s16_r});
  assign x2 = c_s16_r + $signed({1'b0, hs_s16_r});

  always_ff @(posedge clk) begin
    if (en[ST_CORNER]) begin
      x1_s17_r <= clamp_unit(x1);
      x2_s17_r <= clamp_unit(x2);
    end
  end

  // ---- stage 18: scale by image size (saturated to 4096) ----
  logic [12:0] dim_sat;
  logic [56:0] p1_s18_r, p2_s18_r;

  assign dim_sat = (dim > 13'd4096) ? 13'd4096 : dim;

  always_ff @(posedge clk) begin
    if (en[ST_SCALE]) begin
      p1_s18_r <= 57'(x1_s17_r) * 57'(dim_sat);
      p2_s18_r <= 57'(x2_s17_r) * 57'(dim_sat);
    end
  end

  // ---- stage 19: clamp to the last pixel; zero size clamps to zero ----
  logic [55:0] hi;
  logic [55:0] q1_s19_r, q2_s19_r;

  assign hi = (dim_sat == 13'd0) ? 56'd0 : {12'(dim_sat - 13'd1), 44'd0};

  always_ff @(posedge clk) begin
    if (en[ST_CLAMP]) begin
      q1_s19_r <= (p1_s18_r > 57'(hi)) ? hi : p1_s18_r[55:0];
      q2_s19_r <= (p2_s18_r > 57'(hi)) ? hi : p2_s18_r[55:0];
    end
  end

  // ---- stage 20: pixel position and truncated length ----
  logic [55:0] diff;
  logic [11:0] pos_r;
  logic [12:0] len_r;

  assign diff = q2_s19_r - q1_s19_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      pos_r <= q1_s19_r[55:44];
      len_r <= {1'b0, diff[55:44]} + 13'd1;
    end
  end

  assign pos = pos_r;
  assign len = len_r;

endmodule

`default_nettype wire

// File: sv/anchor_box_decode_filter.sv
// ============================================================================
// anchor_box_decode_filter - prior box decode with variances and score gate
// Drops background and low-score priors, decodes kept ones to a clamped
// integer pixel rectangle.
// ============================================================================
//
//   Channel  Direction  Handshake           Payload
//   -------  ---------  ------------------  --------------------------------
//   cfg      in         cfg_we              cfg_index, cfg_wdata
//   in       in         in_valid/in_ready   deltas, prior box, class, score
//   out      out        out_valid/out_ready class, score, box, prior_ref
//
// One item per cycle sustained while out_ready is high. The longest part of
// the pipeline is the exp2 fraction chain: twelve multiply-and-round stages,
// one per fraction bit, in each axis.
// Reset (synchronous, rst_n low) clears all valid bits and loads register
// reset values. A stalled output holds only the stages that are full;
// empty stages keep loading, so in_ready falls only with all 21 stages full.
// Dropped priors are accepted like kept ones and leave a bubble.
//
`default_nettype none

module anchor_box_decode_filter
  import abdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // prior items
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    in_delta_x,
  input  wire logic signed [15:0]    in_delta_y,
  input  wire logic signed [15:0]    in_delta_w,
  input  wire logic signed [15:0]    in_delta_h,
  input  wire logic [15:0]           in_prior_cx,
  input  wire logic [15:0]           in_prior_cy,
  input  wire logic [15:0]           in_prior_w,
  input  wire logic [15:0]           in_prior_h,
  input  wire logic [6:0]            in_best_class,
  input  wire logic [15:0]           in_best_score,
  input  wire logic [14:0]           in_prior_number,
  // detections
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [6:0]                 out_class_id,
  output logic [15:0]                out_score,
  output logic [11:0]                out_box_x,
  output logic [11:0]                out_box_y,
  output logic [12:0]                out_box_w,
  output logic [12:0]                out_box_h,
  output logic [14:0]                out_prior_ref
);

  cfg_t                  cfg;
  side_t                 in_side;
  side_t                 out_side;
  logic [NUM_STAGES-1:0] en;

  abdf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Gather pass-through fields
  assign in_side.class_id  = in_best_class;
  assign in_side.score     = in_best_score;
  assign in_side.prior_ref = in_prior_number;

  abdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_side   (in_side),
    .score_thr (cfg.score_thr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_side  (out_side),
    .en        (en)
  );

  // Horizontal axis
  abdf_axis u_axis_x (
    .clk        (clk),
    .en         (en),
    .var_c      (cfg.var_cx),
    .var_s      (cfg.var_w),
    .dim        (cfg.img_w),
    .delta_c    (in_delta_x),
    .delta_s    (in_delta_w),
    .prior_c    (in_prior_cx),
    .prior_size (in_prior_w),
    .pos        (out_box_x),
    .len        (out_box_w)
  );

  // Vertical axis
  abdf_axis u_axis_y (
    .clk        (clk),
    .en         (en),
    .var_c      (cfg.var_cy),
    .var_s      (cfg.var_h),
    .dim        (cfg.img_h),
    .delta_c    (in_delta_y),
    .delta_s    (in_delta_h),
    .prior_c    (in_prior_cy),
    .prior_size (in_prior_h),
    .pos        (out_box_y),
    .len        (out_box_h)
  );

  assign out_class_id  = out_side.class_id;
  assign out_score     = out_side.score;
  assign out_prior_ref = out_side.prior_ref;

  // A result never carries the background class
  a_fg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_class_id != 7'd0)
    else $error("background class reached the output");

  // The rectangle stays inside a 4096 pixel frame with a non-empty extent
  a_box_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_box_w != 13'd0) &&
                  (({2'b00, out_box_x} + {1'b0, out_box_w}) <= 14'd4096))
    else $error("horizontal extent out of range");

  a_box_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_box_h != 13'd0) &&
                  (({2'b00, out_box_y} + {1'b0, out_box_h}) <= 14'd4096))
    else $error("vertical extent out of range");

endmodule

`default_nettype wire

// File: bench/detection_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// detection_checker - predicts and checks detections of the box decode filter
// Keeps its own copy of the registers and a fixed-point decode of each kept
// prior, then matches every delivered detection against the oldest waiting
// prediction, field by field.
// ============================================================================

module detection_checker
  import abdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic signed [15:0]    in_delta_x,
  input  logic signed [15:0]    in_delta_y,
  input  logic signed [15:0]    in_delta_w,
  input  logic signed [15:0]    in_delta_h,
  input  logic [15:0]           in_prior_cx,
  input  logic [15:0]           in_prior_cy,
  input  logic [15:0]           in_prior_w,
  input  logic [15:0]           in_prior_h,
  input  logic [6:0]            in_best_class,
  input  logic [15:0]           in_best_score,
  input  logic [14:0]           in_prior_number,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [6:0]            out_class_id,
  input  logic [15:0]           out_score,
  input  logic [11:0]           out_box_x,
  input  logic [11:0]           out_box_y,
  input  logic [12:0]           out_box_w,
  input  logic [12:0]           out_box_h,
  input  logic [14:0]           out_prior_ref,
  output int                    fail_count,
  output int                    outstanding
);

  localparam longint LOG2E_FIX   = 64'sd1549082005;  // log2(e), Q2.30
  localparam longint UNIT_Q44    = 64'sd1 <<< 44;
  localparam int     MAX_DIM     = 4096;
  localparam int     PRINT_LIMIT = 40;

  // 2^(2^-k) in Q1.30 for k = 1 .. 12
  localparam bit [30:0] FRAC_STEP [12] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196444, 31'd1074468888, 31'd1074105294, 31'd1073923544
  };

  typedef struct {
    bit [6:0]  class_id;
    bit [15:0] score;
    bit [11:0] box_x;
    bit [11:0] box_y;
    bit [12:0] box_w;
    bit [12:0] box_h;
    bit [14:0] prior_ref;
  } detection_t;

  cfg_t       regs;
  detection_t pending_detections[$];

  task automatic report(input string msg);
    if (fail_count < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input bit [15:0] wanted, input bit [14:0] prior_id);
    if (got !== 16'(wanted))
      report($sformatf("prior %0d %s: got %0h, expected %0h", prior_id, name, got, wanted));
  endtask

  // Half of the decoded size in Q.44: size * 2^(var * delta * log2 e) / 2
  function automatic longint half_extent(bit [15:0] var_s, logic signed [15:0] delta,
                                         bit [15:0] size);
    longint    expo;
    longint    log2_fix;
    bit [63:0] biased;
    bit [63:0] mant;
    bit [63:0] half;
    bit [11:0] frac;
    int        whole;
    int        sh;
    expo   = longint'(var_s) * longint'(delta);
    biased = 64'(expo * LOG2E_FIX) + (64'd1 << 62);
    // floor to Q.12, then saturate to +-12 octaves
    log2_fix = longint'(biased >> 46) - 65536;
    if (log2_fix < -12 * 4096) log2_fix = -12 * 4096;
    if (log2_fix > 12 * 4096 - 1) log2_fix = 12 * 4096 - 1;
    whole = int'(log2_fix >>> 12);
    frac  = log2_fix[11:0];
    // fraction power: one rounded multiply per set bit, heaviest first
    mant = 64'd1 << 30;
    for (int i = 0; i < 12; i++) begin
      if (frac[11-i]) mant = (mant * FRAC_STEP[i] + (64'd1 << 29)) >> 30;
    end
    half = 64'(size) * mant;
    sh   = whole - 3;
    if (sh >= 0) half = half << sh;
    else half = half >> (-sh);
    return longint'(half);
  endfunction

  // Clamp a Q.44 corner to the unit range, scale by the image size, clamp to dim-1
  function automatic bit [63:0] clamp_to_pixels(longint pt, bit [63:0] dim);
    bit [63:0] scaled;
    bit [63:0] lim;
    if (pt < 0) pt = 0;
    if (pt > UNIT_Q44) pt = UNIT_Q44;
    scaled = 64'(pt) * dim;
    lim    = (dim != 0) ? ((dim - 1) << 44) : 64'd0;
    return (scaled > lim) ? lim : scaled;
  endfunction

  // One axis: decoded centre and size turned into pixel start and length
  function automatic void axis_to_pixels(bit [15:0] var_c, logic signed [15:0] d_c,
                                         bit [15:0] var_s, logic signed [15:0] d_s,
                                         bit [15:0] centre, bit [15:0] size,
                                         bit [12:0] dim_reg,
                                         output bit [11:0] pos, output bit [12:0] len);
    longint    mid;
    longint    half;
    bit [63:0] dim;
    bit [63:0] lo;
    bit [63:0] hi;
    mid  = longint'(var_c) * longint'(d_c) * longint'(size) + (longint'(centre) <<< 28);
    half = half_extent(var_s, d_s, size);
    dim  = (dim_reg > MAX_DIM) ? 64'(MAX_DIM) : 64'(dim_reg);
    lo   = clamp_to_pixels(mid - half, dim);
    hi   = clamp_to_pixels(mid + half, dim);
    pos  = 12'(lo >> 44);
    len  = 13'(((hi - lo) >> 44) + 1);
  endfunction

  always @(posedge clk) begin
    detection_t want;
    detection_t made;
    if (!rst_n) begin
      regs = '{var_cx: RST_VAR_C, var_cy: RST_VAR_C, var_w: RST_VAR_S, var_h: RST_VAR_S,
               score_thr: RST_SCORE_THR, img_w: RST_IMG_W, img_h: RST_IMG_H};
      pending_detections.delete();
      fail_count = 0;
    end else begin
      // match a delivered detection with the oldest prediction
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (pending_detections.size() == 0) begin
          report($sformatf("detection for prior %0d with none expected", out_prior_ref));
        end else begin
          want = pending_detections.pop_front();
          compare_field("class_id", 16'(out_class_id), 16'(want.class_id), want.prior_ref);
          compare_field("score", out_score, want.score, want.prior_ref);
          compare_field("box_x", 16'(out_box_x), 16'(want.box_x), want.prior_ref);
          compare_field("box_y", 16'(out_box_y), 16'(want.box_y), want.prior_ref);
          compare_field("box_w", 16'(out_box_w), 16'(want.box_w), want.prior_ref);
          compare_field("box_h", 16'(out_box_h), 16'(want.box_h), want.prior_ref);
          compare_field("prior_ref", 16'(out_prior_ref), 16'(want.prior_ref), want.prior_ref);
        end
      end
      // predict: keep foreground priors scoring above the threshold, drop the rest
      if (in_valid === 1'b1 && in_ready === 1'b1 &&
          in_best_class != '0 && in_best_score > regs.score_thr) begin
        made.class_id  = in_best_class;
        made.score     = in_best_score;
        made.prior_ref = in_prior_number;
        axis_to_pixels(regs.var_cx, in_delta_x, regs.var_w, in_delta_w,
                       in_prior_cx, in_prior_w, regs.img_w, made.box_x, made.box_w);
        axis_to_pixels(regs.var_cy, in_delta_y, regs.var_h, in_delta_h,
                       in_prior_cy, in_prior_h, regs.img_h, made.box_y, made.box_h);
        pending_detections.insert(pending_detections.size(), made);
      end
      // hold the register copy in step with the block
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_VAR_CX:    regs.var_cx    = cfg_wdata;
          CFG_VAR_CY:    regs.var_cy    = cfg_wdata;
          CFG_VAR_W:     regs.var_w     = cfg_wdata;
          CFG_VAR_H:     regs.var_h     = cfg_wdata;
          CFG_SCORE_THR: regs.score_thr = cfg_wdata;
          CFG_IMG_W:     regs.img_w     = cfg_wdata[12:0];
          CFG_IMG_H:     regs.img_h     = cfg_wdata[12:0];
          default: ;
        endcase
      end
    end
    outstanding <= pending_detections.size();
  end

endmodule

// File: bench/tb_anchor_box_decode_filter.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_anchor_box_decode_filter - testbench for the anchor box decode filter
// Drives directed and random priors under several register settings, with
// random gaps on the prior side and stalls on the detection side; the
// checker beside the block predicts and compares every detection.
// ============================================================================

module tb_anchor_box_decode_filter;
  import abdf_pkg::*;

  localparam int PIPE_DEPTH  = 21;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // beyond the register list

  typedef struct {
    bit signed [15:0] delta_x;
    bit signed [15:0] delta_y;
    bit signed [15:0] delta_w;
    bit signed [15:0] delta_h;
    bit [15:0]        cx;
    bit [15:0]        cy;
    bit [15:0]        w;
    bit [15:0]        h;
    bit [6:0]         cls;
    bit [15:0]        score;
    bit [14:0]        number;
  } prior_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [15:0]    in_delta_x, in_delta_y, in_delta_w, in_delta_h;
  logic [15:0]           in_prior_cx, in_prior_cy, in_prior_w, in_prior_h;
  logic [6:0]            in_best_class;
  logic [15:0]           in_best_score;
  logic [14:0]           in_prior_number;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [6:0]            out_class_id;
  logic [15:0]           out_score;
  logic [11:0]           out_box_x, out_box_y;
  logic [12:0]           out_box_w, out_box_h;
  logic [14:0]           out_prior_ref;
  int                    fail_count;
  int                    outstanding;
  logic                  steady = 1'b0;
  int                    hold_left = 0;
  int                    cycles;
  bit [15:0]             cur_thr;

  always #2 clk = ~clk;

  anchor_box_decode_filter uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_delta_x(in_delta_x), .in_delta_y(in_delta_y),
    .in_delta_w(in_delta_w), .in_delta_h(in_delta_h),
    .in_prior_cx(in_prior_cx), .in_prior_cy(in_prior_cy),
    .in_prior_w(in_prior_w), .in_prior_h(in_prior_h),
    .in_best_class(in_best_class), .in_best_score(in_best_score),
    .in_prior_number(in_prior_number),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_class_id(out_class_id), .out_score(out_score),
    .out_box_x(out_box_x), .out_box_y(out_box_y),
    .out_box_w(out_box_w), .out_box_h(out_box_h),
    .out_prior_ref(out_prior_ref)
  );

  detection_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_delta_x(in_delta_x), .in_delta_y(in_delta_y),
    .in_delta_w(in_delta_w), .in_delta_h(in_delta_h),
    .in_prior_cx(in_prior_cx), .in_prior_cy(in_prior_cy),
    .in_prior_w(in_prior_w), .in_prior_h(in_prior_h),
    .in_best_class(in_best_class), .in_best_score(in_best_score),
    .in_prior_number(in_prior_number),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_class_id(out_class_id), .out_score(out_score),
    .out_box_x(out_box_x), .out_box_y(out_box_y),
    .out_box_w(out_box_w), .out_box_h(out_box_h),
    .out_prior_ref(out_prior_ref),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Detection side: random stalls, a rare long one, no new stall begun while steady
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(999) < 2) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(40, 20);
    end else begin
      out_ready <= ($urandom_range(99) >= 33);
    end
  end

  function automatic prior_t prior_of(bit [15:0] dx, bit [15:0] dy, bit [15:0] dw,
                                      bit [15:0] dh, bit [15:0] cx, bit [15:0] cy,
                                      bit [15:0] w, bit [15:0] h, bit [6:0] cls,
                                      bit [15:0] score, bit [14:0] number);
    prior_t p;
    p = '{delta_x: dx, delta_y: dy, delta_w: dw, delta_h: dh, cx: cx, cy: cy,
          w: w, h: h, cls: cls, score: score, number: number};
    return p;
  endfunction

  // Mostly offsets within +-2.0, now and then the full Q4.12 range
  function automatic bit signed [15:0] random_delta();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(16384) - 8192);
  endfunction

  // Mostly kept priors with random content, the rest background or weak scores
  function automatic prior_t random_prior();
    prior_t p;
    int     pick;
    p.delta_x = random_delta();
    p.delta_y = random_delta();
    p.delta_w = random_delta();
    p.delta_h = random_delta();
    p.cx      = 16'($urandom);
    p.cy      = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      p.w = 16'($urandom);
      p.h = 16'($urandom);
    end else begin
      p.w = 16'($urandom_range(40000, 300));
      p.h = 16'($urandom_range(40000, 300));
    end
    p.number = 15'($urandom);
    pick = $urandom_range(99);
    if (pick < 75 && cur_thr != 16'hFFFF) begin
      p.cls   = 7'($urandom_range(127, 1));
      p.score = 16'($urandom_range(65535, int'(cur_thr) + 1));
    end else if (pick < 88) begin
      p.cls   = '0;
      p.score = 16'($urandom);
    end else begin
      p.cls   = 7'($urandom);
      p.score = 16'($urandom_range(int'(cur_thr), 0));
    end
    return p;
  endfunction

  // Present one prior, after a random gap unless steady, and wait for acceptance
  task automatic send_prior(input prior_t p);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 33) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_delta_x      <= p.delta_x;
    in_delta_y      <= p.delta_y;
    in_delta_w      <= p.delta_w;
    in_delta_h      <= p.delta_h;
    in_prior_cx     <= p.cx;
    in_prior_cy     <= p.cy;
    in_prior_w      <= p.w;
    in_prior_h      <= p.h;
    in_best_class   <= p.cls;
    in_best_score   <= p.score;
    in_prior_number <= p.number;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_prior(random_prior());
  endtask

  // Stop sending and wait until every predicted detection has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Reprogram every register once the pipeline has emptied
  task automatic load_settings(input bit [15:0] vcx, input bit [15:0] vcy,
                               input bit [15:0] vw, input bit [15:0] vh,
                               input bit [15:0] thr, input bit [15:0] iw,
                               input bit [15:0] ih);
    drain_results();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    write_reg(CFG_VAR_CX, vcx);
    write_reg(CFG_VAR_CY, vcy);
    write_reg(CFG_VAR_W, vw);
    write_reg(CFG_VAR_H, vh);
    write_reg(CFG_SCORE_THR, thr);
    write_reg(CFG_IMG_W, iw);
    write_reg(CFG_IMG_H, ih);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_we  <= 1'b0;
    cur_thr = thr;
  endtask

  // Give up on a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_VAR_CX;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    {in_delta_x, in_delta_y, in_delta_w, in_delta_h} = '0;
    {in_prior_cx, in_prior_cy, in_prior_w, in_prior_h} = '0;
    {in_best_class, in_best_score, in_prior_number} = '0;
    cur_thr = RST_SCORE_THR;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed priors under the reset settings
    send_prior(prior_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                        16'h4000, 16'h4000, 7'd1, 16'd40000, 15'd0));
    // background class, dropped
    send_prior(prior_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                        16'h4000, 16'h4000, 7'd0, 16'hFFFF, 15'd1));
    // score equal to threshold, dropped; one above, kept
    send_prior(prior_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                        16'h4000, 16'h4000, 7'd5, 16'd3277, 15'd2));
    send_prior(prior_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                        16'h4000, 16'h4000, 7'd127, 16'd3278, 15'd3));
    // field extremes
    send_prior(prior_of(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 7'd127, 16'hFFFF, 15'h7FFF));
    send_prior(prior_of(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 7'd1, 16'hFFFF, 15'd0));
    // box far larger than the image, and nearly vanished
    send_prior(prior_of(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                        16'hFFFF, 16'hFFFF, 7'd2, 16'd20000, 15'd100));
    send_prior(prior_of(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'hFFFF, 16'hFFFF, 7'd3, 16'd20000, 15'd101));
    // zero-size priors at both corners
    send_prior(prior_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 7'd4, 16'd20000, 15'd102));
    send_prior(prior_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                        16'h0000, 16'h0000, 7'd4, 16'd20000, 15'd103));
    // centre on either edge, pushed towards the middle
    send_prior(prior_of(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                        16'h2000, 16'h2000, 7'd9, 16'd30000, 15'd104));
    // alternating bit patterns
    send_prior(prior_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                        16'h5555, 16'hAAAA, 7'h55, 16'hAAAA, 15'h5555));
    send_prior(prior_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'hAAAA, 16'h5555, 7'h2A, 16'h5555, 15'h2AAA));
    // zero score, dropped
    send_prior(prior_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                        16'h4000, 16'h4000, 7'd3, 16'h0000, 15'd105));
    send_prior(prior_of(16'h1000, 16'hF000, 16'h0800, 16'hF800, 16'h4000, 16'hC000,
                        16'h2000, 16'h6000, 7'd10, 16'd60000, 15'h7FFE));

    // Reset settings: a stretch with no idling, a full pause, then idling again
    steady <= 1'b1;
    run_random(75);
    drain_results();
    steady <= 1'b0;
    run_random(75);

    // Zero variances and threshold, one-pixel image
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1, 16'd1);
    run_random(60);

    // Full variances, highest usable threshold, largest image
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'd4096, 16'd4096);
    run_random(100);

    // Threshold at its top: nothing can pass
    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'hFFFF, 16'd640, 16'd480);
    run_random(20);

    // Image size zero
    load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(20000)),
                  16'($urandom_range(20000)), 16'h0000, 16'd0, 16'd0);
    run_random(60);

    // Image size above the limit, high bits of the write data set
    load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(20000)),
                  16'($urandom_range(20000)), 16'd1000, 16'hFFFF, 16'd4097);
    run_random(60);

    // Random settings
    repeat (4) begin
      load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(20000)),
                    16'($urandom_range(20000)), 16'($urandom_range(40000)),
                    16'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1)));
      run_random(80);
    end

    drain_results();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
